/* rtl/core/lru_ts_pkg.sv */
// ----------------------------------------------------------------------------
// lru_ts_pkg
// Shared types and constants of the timestamp LRU replacement core.
// ----------------------------------------------------------------------------
package lru_ts_pkg;

  localparam int NUM_SETS_DEF  = 64;
  localparam int MAX_WAYS_DEF  = 8;
  localparam int TAG_BITS_DEF  = 20;
  localparam int TIME_BITS_DEF = 32;

  localparam int OP_W      = 2;
  localparam int SET_IDX_W = 6;
  localparam int WAY_IN_W  = 3;
  localparam int TAG_IN_W  = 20;
  localparam int VICTIM_W  = 3;
  localparam int CFG_W     = 4;

  localparam logic [CFG_W-1:0] CFG_WAYS_RESET = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_ACCESS  = 2'd0,
    OP_QUERY   = 2'd1,
    OP_INSTALL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic write;
    logic scan;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic clear_last;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/lru_ts_in_if.sv */
// ----------------------------------------------------------------------------
// lru_ts_in_if
// Request channel: access, victim query and tag install items.
// ----------------------------------------------------------------------------
interface lru_ts_in_if;
  logic                               valid;
  logic                               ready;
  logic [lru_ts_pkg::OP_W-1:0]        op;
  logic [lru_ts_pkg::SET_IDX_W-1:0]   set_index;
  logic [lru_ts_pkg::WAY_IN_W-1:0]    way;
  logic [lru_ts_pkg::TAG_IN_W-1:0]    tag;

  modport source (output valid, output op, output set_index, output way, output tag,
                  input ready);
  modport sink   (input valid, input op, input set_index, input way, input tag,
                  output ready);
endinterface

/* rtl/core/lru_ts_out_if.sv */
// ----------------------------------------------------------------------------
// lru_ts_out_if
// Result channel: victim way of a query.
// ----------------------------------------------------------------------------
interface lru_ts_out_if;
  logic                              valid;
  logic                              ready;
  logic [lru_ts_pkg::VICTIM_W-1:0]   victim_way;

  modport source (output valid, output victim_way, input ready);
  modport sink   (input valid, input victim_way, output ready);
endinterface

/* rtl/core/lru_timestamp_replacement_core.sv */
// ----------------------------------------------------------------------------
// lru_timestamp_replacement_core
// Timestamp LRU replacement policy for a set-associative cache.
//
//   Channel   Dir  Handshake          Payload
//   in_ch     in   valid/ready        op, set_index, way, tag
//   out_ch    out  valid/ready        victim_way
//   cfg_*     in   cfg_we, no ready   cfg_wdata (ways in use)
//
// An access or a tag install reads the set's rows from the tag and stamp
// memories, then writes the updated row back.
// A victim query scans the stamps of the N ways in use, comparing one stored
// stamp per cycle against the oldest so far, and may then wait on out_ch.
// After reset, a clearing pass writes one row per cycle through every set
// before in_ch is ready. A result waits in the output register while the next
// item is taken.
// ----------------------------------------------------------------------------
module lru_timestamp_replacement_core #(
  parameter int NUM_SETS  = lru_ts_pkg::NUM_SETS_DEF,
  parameter int MAX_WAYS  = lru_ts_pkg::MAX_WAYS_DEF,
  parameter int TAG_BITS  = lru_ts_pkg::TAG_BITS_DEF,
  parameter int TIME_BITS = lru_ts_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lru_ts_in_if.sink                     in_ch,
  lru_ts_out_if.source                  out_ch,
  input  logic                          cfg_we,
  input  logic [lru_ts_pkg::CFG_W-1:0]  cfg_wdata
);
  import lru_ts_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;
  logic [VICTIM_W-1:0] out_victim_way;

  lru_ts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lru_ts_dp #(
    .NUM_SETS  (NUM_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .TAG_BITS  (TAG_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_op          (in_ch.op),
    .in_set_index   (in_ch.set_index),
    .in_way         (in_ch.way),
    .in_tag         (in_ch.tag),
    .out_ready      (out_ch.ready),
    .out_valid      (out_valid),
    .out_victim_way (out_victim_way)
  );

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.victim_way = out_victim_way;

endmodule

/* rtl/core/lru_ts_ctrl.sv */
// ----------------------------------------------------------------------------
// lru_ts_ctrl
// Sequencer: clearing pass, item capture, row write-back and victim scan.
// ----------------------------------------------------------------------------
module lru_ts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lru_ts_pkg::sts_t  sts,
  output lru_ts_pkg::cmd_t  cmd
);
  import lru_ts_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (sts.in_op) inside
            OP_ACCESS, OP_INSTALL: state_nxt = ST_WRITE;
            OP_QUERY:              state_nxt = ST_SCAN;
            default:               state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: begin
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (sts.scan_done && sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan     = 1'b1;
        cmd.load_out = sts.scan_done && sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/core/lru_ts_dp.sv */
// ----------------------------------------------------------------------------
// lru_ts_dp
// Datapath: tag and stamp row memories, time counter, way match, victim scan
// and the result register.
// ----------------------------------------------------------------------------
module lru_ts_dp #(
  parameter int NUM_SETS  = lru_ts_pkg::NUM_SETS_DEF,
  parameter int MAX_WAYS  = lru_ts_pkg::MAX_WAYS_DEF,
  parameter int TAG_BITS  = lru_ts_pkg::TAG_BITS_DEF,
  parameter int TIME_BITS = lru_ts_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lru_ts_pkg::cmd_t                    cmd,
  output lru_ts_pkg::sts_t                    sts,
  input  logic                                cfg_we,
  input  logic [lru_ts_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [lru_ts_pkg::OP_W-1:0]         in_op,
  input  logic [lru_ts_pkg::SET_IDX_W-1:0]    in_set_index,
  input  logic [lru_ts_pkg::WAY_IN_W-1:0]     in_way,
  input  logic [lru_ts_pkg::TAG_IN_W-1:0]     in_tag,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [lru_ts_pkg::VICTIM_W-1:0]     out_victim_way
);
  import lru_ts_pkg::*;

  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W = $clog2(MAX_WAYS + 1);

  typedef logic [MAX_WAYS-1:0][TAG_BITS-1:0]  tag_row_t;
  typedef logic [MAX_WAYS-1:0][TIME_BITS-1:0] stamp_row_t;

  tag_row_t   tag_mem   [NUM_SETS];
  stamp_row_t stamp_mem [NUM_SETS];

  logic [CFG_W-1:0]     cfg_ways_r, cfg_ways_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [SET_W-1:0]     clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [WAY_W-1:0]     best_r, best_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [VICTIM_W-1:0]  victim_r, victim_nxt;

  logic [OP_W-1:0]      op_r;
  logic [SET_W-1:0]     set_r;
  logic [WAY_IN_W-1:0]  way_r;
  logic [TAG_BITS-1:0]  tag_r;
  tag_row_t             tag_rd_r;
  stamp_row_t           stamp_rd_r;

  logic [SET_IDX_W-1:0]         set_mod;
  logic [SET_IDX_W+SET_W-1:0]   set_x;
  logic [SET_W-1:0]             rd_addr;
  logic [TAG_IN_W+TAG_BITS-1:0] tag_x;
  logic [TAG_BITS-1:0]          tag_k;
  logic [CFG_W:0]               n_x;
  logic [CNT_W-1:0]             ways_n;
  logic                         hit;
  logic [WAY_W-1:0]             hit_way;
  logic [WAY_IN_W+WAY_W-1:0]    way_x;
  logic                         way_ok;
  logic [CNT_W+WAY_W-1:0]       idx_x;
  logic [WAY_W-1:0]             idx_w;
  logic                         scan_active;
  logic [WAY_W+VICTIM_W-1:0]    best_x;
  logic                         tag_we, stamp_we;
  logic [SET_W-1:0]             wr_addr;
  tag_row_t                     tag_wr_row;
  stamp_row_t                   stamp_wr_row;

  always_comb begin
    set_mod = in_set_index;
    for (int i = SET_IDX_W - 1; i >= 0; i--) begin
      if (32'(set_mod) >= (NUM_SETS << i)) begin
        set_mod = set_mod - SET_IDX_W'(NUM_SETS << i);
      end
    end
    set_x   = (SET_IDX_W + SET_W)'(set_mod);
    rd_addr = set_x[SET_W-1:0];
    tag_x   = (TAG_IN_W + TAG_BITS)'(in_tag);
    tag_k   = tag_x[TAG_BITS-1:0];
  end

  always_comb begin
    if (cfg_ways_r == '0) begin
      n_x = (CFG_W + 1)'(1);
    end else if ({1'b0, cfg_ways_r} > (CFG_W + 1)'(MAX_WAYS)) begin
      n_x = (CFG_W + 1)'(MAX_WAYS);
    end else begin
      n_x = {1'b0, cfg_ways_r};
    end
    ways_n = n_x[CNT_W-1:0];
  end

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if ((w < 32'(ways_n)) && (tag_rd_r[w] == tag_r)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    way_x  = (WAY_IN_W + WAY_W)'(way_r);
    way_ok = 32'(way_r) < MAX_WAYS;

    tag_wr_row   = tag_rd_r;
    stamp_wr_row = stamp_rd_r;
    tag_wr_row[way_x[WAY_W-1:0]] = tag_r;
    stamp_wr_row[hit_way]        = time_r;

    tag_we   = cmd.clear || (cmd.write && (op_r == OP_INSTALL) && way_ok);
    stamp_we = cmd.clear || (cmd.write && (op_r == OP_ACCESS) && hit);
    wr_addr  = cmd.clear ? clr_idx_r : set_r;
    if (cmd.clear) begin
      tag_wr_row   = '0;
      stamp_wr_row = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[wr_addr] <= tag_wr_row;
    if (cmd.capture) tag_rd_r <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (stamp_we) stamp_mem[wr_addr] <= stamp_wr_row;
    if (cmd.capture) stamp_rd_r <= stamp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      set_r <= rd_addr;
      way_r <= in_way;
      tag_r <= tag_k;
    end
  end

  always_comb begin
    idx_x       = (CNT_W + WAY_W)'(idx_r);
    idx_w       = idx_x[WAY_W-1:0];
    scan_active = cmd.scan && (idx_r < ways_n);
    best_x      = (WAY_W + VICTIM_W)'(best_r);

    cfg_ways_nxt  = cfg_we ? cfg_wdata : cfg_ways_r;
    time_nxt      = time_r;
    clr_idx_nxt   = clr_idx_r;
    idx_nxt       = idx_r;
    best_nxt      = best_r;
    victim_nxt    = victim_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;

    if (cmd.clear) begin
      clr_idx_nxt = clr_idx_r + SET_W'(1);
    end
    if (cmd.capture) begin
      idx_nxt  = CNT_W'(1);
      best_nxt = '0;
      if (in_op == OP_ACCESS) begin
        time_nxt = time_r + TIME_BITS'(1);
      end
    end
    if (scan_active) begin
      idx_nxt = idx_r + CNT_W'(1);
      if (stamp_rd_r[idx_w] < stamp_rd_r[best_r]) begin
        best_nxt = idx_w;
      end
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      victim_nxt    = best_x[VICTIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ways_r  <= CFG_WAYS_RESET;
      time_r      <= '0;
      clr_idx_r   <= '0;
      idx_r       <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_ways_r  <= cfg_ways_nxt;
      time_r      <= time_nxt;
      clr_idx_r   <= clr_idx_nxt;
      idx_r       <= idx_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    victim_r <= victim_nxt;
  end

  always_comb begin
    sts.in_op      = op_t'(in_op);
    sts.clear_last = clr_idx_r == SET_W'(NUM_SETS - 1);
    sts.scan_done  = idx_r >= ways_n;
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_victim_way = victim_r;

endmodule

/* rtl/core/lru_ts_chk.sv */
// ----------------------------------------------------------------------------
// lru_ts_chk
// Port-level checks of the timestamp LRU replacement core, bound to its top.
// ----------------------------------------------------------------------------
module lru_ts_chk #(
  parameter int MAX_WAYS = lru_ts_pkg::MAX_WAYS_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [lru_ts_pkg::OP_W-1:0]        in_op,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [lru_ts_pkg::VICTIM_W-1:0]    out_victim_way
);
  import lru_ts_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // An access or install transfer closes the input side for its write-back, then reopens it.
  a_update_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_op == OP_ACCESS || in_op == OP_INSTALL)) |=> !in_ready ##1 in_ready)
    else $error("update item did not take exactly two cycles");

  // A victim query closes the input side once it is taken, as its scan begins.
  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_op == OP_QUERY) |=> !in_ready)
    else $error("input taken during victim scan");

  // The victim lies inside the row.
  a_victim_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_victim_way) < MAX_WAYS))
    else $error("victim way outside the row");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_victim_way)))
    else $error("stalled result changed");

endmodule

bind lru_timestamp_replacement_core lru_ts_chk #(
  .MAX_WAYS (MAX_WAYS)
) u_lru_ts_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_op          (in_ch.op),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_victim_way (out_ch.victim_way)
);

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timestamp LRU replacement core. A directed table
// and random item streams drive the request channel under several way counts,
// and each victim way is checked against an in-bench model of the tag and
// stamp stores or, for some directed rows, against a victim given in the table,
// with random stalls on both channels.
module tb;
  import lru_ts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETS = NUM_SETS_DEF;
  localparam int WAYS = MAX_WAYS_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [SET_IDX_W-1:0] set_idx;
    logic [WAY_IN_W-1:0]  way;
    logic [TAG_IN_W-1:0]  tag;
    logic                 typed;
    logic [VICTIM_W-1:0]  victim;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  lru_ts_in_if  in_ch();
  lru_ts_out_if out_ch();

  lru_timestamp_replacement_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  logic [TAG_IN_W-1:0]      tag_store   [SETS][WAYS];
  logic [TIME_BITS_DEF-1:0] stamp_store [SETS][WAYS];
  logic [TIME_BITS_DEF-1:0] use_clock;
  logic [CFG_W-1:0]         ways_reg;
  logic [VICTIM_W-1:0]      victim_queue [$];
  int                       err_count;
  bit                       idle_on;
  int                       quiet_cycles;

  stim_row_t dir_rows [23] = '{
    '{OP_QUERY,   6'd0,  3'd0, 20'h00000, 1'b1, 3'd0},
    '{OP_QUERY,   6'd63, 3'd0, 20'h00000, 1'b1, 3'd0},
    '{OP_ACCESS,  6'd0,  3'd0, 20'h00000, 1'b0, 3'd0},
    '{OP_QUERY,   6'd0,  3'd0, 20'h00000, 1'b1, 3'd1},
    '{OP_INSTALL, 6'd5,  3'd7, 20'hFFFFF, 1'b0, 3'd0},
    '{OP_INSTALL, 6'd5,  3'd0, 20'h00001, 1'b0, 3'd0},
    '{OP_INSTALL, 6'd5,  3'd3, 20'hABCDE, 1'b0, 3'd0},
    '{OP_INSTALL, 6'd5,  3'd6, 20'hABCDE, 1'b0, 3'd0},
    '{OP_ACCESS,  6'd5,  3'd0, 20'hABCDE, 1'b0, 3'd0},
    '{OP_ACCESS,  6'd5,  3'd0, 20'hFFFFF, 1'b0, 3'd0},
    '{OP_ACCESS,  6'd5,  3'd0, 20'h00001, 1'b0, 3'd0},
    '{OP_ACCESS,  6'd5,  3'd0, 20'h00000, 1'b0, 3'd0},
    '{OP_QUERY,   6'd5,  3'd0, 20'h00000, 1'b0, 3'd0},
    '{OP_ACCESS,  6'd5,  3'd0, 20'h12345, 1'b0, 3'd0},
    '{OP_UNUSED,  6'd63, 3'd7, 20'hFFFFF, 1'b0, 3'd0},
    '{OP_INSTALL, 6'd63, 3'd7, 20'hFFFFF, 1'b0, 3'd0},
    '{OP_ACCESS,  6'd63, 3'd7, 20'hFFFFF, 1'b0, 3'd0},
    '{OP_QUERY,   6'd63, 3'd7, 20'hFFFFF, 1'b0, 3'd0},
    '{OP_INSTALL, 6'd42, 3'd2, 20'hAAAAA, 1'b0, 3'd0},
    '{OP_ACCESS,  6'd42, 3'd5, 20'hAAAAA, 1'b0, 3'd0},
    '{OP_ACCESS,  6'd21, 3'd2, 20'h00000, 1'b0, 3'd0},
    '{OP_QUERY,   6'd42, 3'd5, 20'h55555, 1'b0, 3'd0},
    '{OP_QUERY,   6'd21, 3'd2, 20'hAAAAA, 1'b0, 3'd0}
  };

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    err_count++;
  endtask

  // Updates the tag and stamp stores for one item and gives the victim of a
  // query.
  task automatic lru_apply(input logic [OP_W-1:0] op, input logic [SET_IDX_W-1:0] set_idx,
                           input logic [WAY_IN_W-1:0] way, input logic [TAG_IN_W-1:0] tag,
                           output bit has_victim, output logic [VICTIM_W-1:0] victim);
    int n;
    int w;
    bit hit;
    logic [TIME_BITS_DEF-1:0] low_stamp;
    n = (ways_reg == 0) ? 1 : ((ways_reg > WAYS) ? WAYS : int'(ways_reg));
    has_victim = 1'b0;
    victim = '0;
    case (op)
      OP_ACCESS: begin
        use_clock = use_clock + 1;
        hit = 1'b0;
        for (w = 0; w < n; w++) begin
          if (!hit && tag_store[set_idx][w] == tag) begin
            stamp_store[set_idx][w] = use_clock;
            hit = 1'b1;
          end
        end
      end
      OP_QUERY: begin
        low_stamp = stamp_store[set_idx][0];
        for (w = 1; w < n; w++) begin
          if (stamp_store[set_idx][w] < low_stamp) begin
            low_stamp = stamp_store[set_idx][w];
            victim = w[VICTIM_W-1:0];
          end
        end
        has_victim = 1'b1;
      end
      OP_INSTALL: tag_store[set_idx][way] = tag;
      default: ;
    endcase
  endtask

  task automatic push_item(input logic [OP_W-1:0] op, input logic [SET_IDX_W-1:0] set_idx,
                           input logic [WAY_IN_W-1:0] way, input logic [TAG_IN_W-1:0] tag,
                           input logic typed, input logic [VICTIM_W-1:0] typed_victim);
    bit has_victim;
    logic [VICTIM_W-1:0] victim;
    int gap;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.op = op;
    in_ch.set_index = set_idx;
    in_ch.way = way;
    in_ch.tag = tag;
    do @(posedge clk); while (!in_ch.ready);
    lru_apply(op, set_idx, way, tag, has_victim, victim);
    if (has_victim) victim_queue.push_back(typed ? typed_victim : victim);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (victim_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ways(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    ways_reg = value;
  endtask

  task automatic run_random(input int count, input bit quiet);
    logic [SET_IDX_W-1:0] hot_sets [4];
    logic [TAG_IN_W-1:0]  hot_tags [6];
    logic [OP_W-1:0]      op;
    logic [SET_IDX_W-1:0] set_idx;
    logic [WAY_IN_W-1:0]  way;
    logic [TAG_IN_W-1:0]  tag;
    int r;
    for (int i = 0; i < 4; i++) hot_sets[i] = SET_IDX_W'($urandom_range(0, SETS - 1));
    for (int i = 0; i < 6; i++) hot_tags[i] = TAG_IN_W'($urandom_range(0, 20'hFFFFF));
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) idle_on = !quiet && ($urandom_range(0, 3) != 0);
      set_idx = ($urandom_range(0, 99) < 85) ? hot_sets[$urandom_range(0, 3)]
                                             : SET_IDX_W'($urandom_range(0, SETS - 1));
      way = WAY_IN_W'($urandom_range(0, WAYS - 1));
      tag = TAG_IN_W'($urandom_range(0, 20'hFFFFF));
      r = $urandom_range(0, 99);
      if (r < 45) begin
        op = OP_ACCESS;
        if ($urandom_range(0, 3) != 0) tag = tag_store[set_idx][$urandom_range(0, WAYS - 1)];
      end else if (r < 70) begin
        op = OP_QUERY;
      end else if (r < 95) begin
        op = OP_INSTALL;
        if ($urandom_range(0, 1) != 0) tag = hot_tags[$urandom_range(0, 5)];
      end else begin
        op = OP_UNUSED;
      end
      push_item(op, set_idx, way, tag, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    logic [VICTIM_W-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (victim_queue.size() == 0) begin
        report_mismatch($sformatf("victim way %0d with no query pending", out_ch.victim_way));
      end else begin
        want = victim_queue.pop_front();
        if (out_ch.victim_way !== want)
          report_mismatch($sformatf("victim_way %0d, expected %0d", out_ch.victim_way, want));
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CFG_W-1:0] ways_plan [6];
    ways_plan = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd6, 4'd8};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.set_index = '0;
    in_ch.way = '0;
    in_ch.tag = '0;
    err_count = 0;
    idle_on = 1'b0;
    quiet_cycles = 0;
    use_clock = '0;
    ways_reg = CFG_WAYS_RESET;
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        tag_store[s][w] = '0;
        stamp_store[s][w] = '0;
      end
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    idle_on = 1'b1;
    foreach (dir_rows[i])
      push_item(dir_rows[i].op, dir_rows[i].set_idx, dir_rows[i].way, dir_rows[i].tag,
                dir_rows[i].typed, dir_rows[i].victim);
    run_random(110, 1'b0);

    foreach (ways_plan[p]) begin
      drain_results();
      write_ways(ways_plan[p]);
      run_random(120, p == 5);
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (victim_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/lru_ts_pkg.sv
rtl/core/lru_ts_in_if.sv
rtl/core/lru_ts_out_if.sv
rtl/core/lru_ts_ctrl.sv
rtl/core/lru_ts_dp.sv
rtl/core/lru_timestamp_replacement_core.sv
rtl/core/lru_ts_chk.sv
tb/sv/tb.sv
